[hw/rtl/telemetry_path_cost_ranker_defines.svh]
// ----------------------------------------------------------------------------
// telemetry_path_cost_ranker_defines
// Assertion macros used by the ranker top level.
// ----------------------------------------------------------------------------
`ifndef TELEMETRY_PATH_COST_RANKER_DEFINES_SVH
`define TELEMETRY_PATH_COST_RANKER_DEFINES_SVH

// Implication check, reset gated.
`define TPCR_ASSERT_IMP(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");

// Next-cycle implication check, reset gated.
`define TPCR_ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");

`endif

[hw/rtl/tpcr_pkg.sv]
// ----------------------------------------------------------------------------
// tpcr_pkg
// Shared types and constants of the telemetry path cost ranker.
// ----------------------------------------------------------------------------
package tpcr_pkg;

	localparam int NODES    = 16;
	localparam int SWITCHES = 16;
	localparam int PORTS    = 8;
	localparam int MAX_HOPS = 8;
	localparam int WINDOW   = 5;

	localparam logic [18:0] SAT19 = 19'h7FFFF;

	localparam logic [1:0] OP_PROBE = 2'd0;
	localparam logic [1:0] OP_LOAD  = 2'd1;
	localparam logic [1:0] OP_RANK  = 2'd2;
	localparam logic [1:0] OP_NOP   = 2'd3;

	localparam logic [1:0] STRAT_QSUM = 2'd0;
	localparam logic [1:0] STRAT_HOPS = 2'd1;

	// Register byte addresses
	localparam logic [2:0] REG_MIN_NODE = 3'd0;
	localparam logic [2:0] REG_MAX_NODE = 3'd4;

	// Insert index marking a hop accumulate step
	localparam logic [4:0] INS_ACC = 5'h1F;

	localparam logic [1:0] QDEPTH = 2'd2;

	// One queued command between front and back.
	typedef struct packed {
		logic [1:0]  opcode;
		logic [3:0]  switch_id;
		logic [2:0]  port_id;
		logic [15:0] queue_depth;
		logic [3:0]  source_node;
		logic [3:0]  dest_node;
		logic [2:0]  hop_index;
		logic [3:0]  hop_count;
		logic [1:0]  strategy;
	} cmd_t;

	// One result item.
	typedef struct packed {
		logic        result_kind;
		logic [3:0]  ranked_node;
		logic [18:0] path_cost;
		logic [18:0] window_sum;
		logic        last;
	} res_t;

endpackage

[hw/rtl/tpcr_front.sv]
// ----------------------------------------------------------------------------
// tpcr_front
// Accepts items, drops unused opcodes, and queues the rest for the back end.
// ----------------------------------------------------------------------------
module tpcr_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  tpcr_pkg::cmd_t     in_cmd,
	output logic               q_valid,
	input  logic               q_ready,
	output tpcr_pkg::cmd_t     q_cmd
);

	tpcr_pkg::cmd_t mem_q [tpcr_pkg::QDEPTH];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign in_ready = (cnt_q != tpcr_pkg::QDEPTH);
	// Unused opcode is taken and discarded.
	assign push  = in_valid && in_ready && (in_cmd.opcode != tpcr_pkg::OP_NOP);
	assign pop   = q_valid && q_ready;
	assign q_valid = (cnt_q != 2'd0);
	assign q_cmd = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

[hw/rtl/tpcr_back.sv]
// ----------------------------------------------------------------------------
// tpcr_back
// Executes probe updates, hop loads and rank queries over the state tables.
// ----------------------------------------------------------------------------
module tpcr_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [3:0]      min_node,
	input  logic [3:0]      max_node,
	input  logic            q_valid,
	output logic            q_ready,
	input  tpcr_pkg::cmd_t  q_cmd,
	output logic            out_valid,
	input  logic            out_ready,
	output tpcr_pkg::res_t  out_res
);

	typedef enum logic [10:0] {
		ST_IDLE  = 11'b00000000001,
		ST_PRB1  = 11'b00000000010,
		ST_PRB2  = 11'b00000000100,
		ST_NODE  = 11'b00000001000,
		ST_HOP   = 11'b00000010000,
		ST_HOPRD = 11'b00000100000,
		ST_INS   = 11'b00001000000,
		ST_EMITR = 11'b00010000000,
		ST_EMITW = 11'b00100000000,
		ST_WAIT  = 11'b01000000000,
		ST_CLR   = 11'b10000000000
	} state_t;

	state_t state_q;
	tpcr_pkg::cmd_t cmd_q;

	// State tables
	logic [15:0] occ_mem   [128];
	logic [15:0] win_mem   [640];
	logic [6:0]  hop_mem   [2048];
	logic [2:0]  fill_mem  [128];
	logic [2:0]  head_mem  [128];
	logic [18:0] tot_mem   [128];
	logic [3:0]  len_mem   [256];
	logic [7:0]  clr_q;      // clearing pass index after reset

	// Probe pipeline registers
	logic [6:0]  port_q;
	logic [2:0]  fill_q, head_q;
	logic [18:0] tot_q;
	logic [15:0] old_q;
	logic [9:0]  widx_q;

	// Rank state
	logic [3:0]  node_q;
	logic [3:0]  len_q;
	logic [2:0]  hop_q;
	logic [18:0] cost_q;
	logic [6:0]  hop_rd_q;
	logic [15:0] occ_rd_q;
	logic [22:0] rb_q [16];
	logic [4:0]  n_q;
	logic [4:0]  ins_q;
	logic [4:0]  emit_q;

	tpcr_pkg::res_t res_q;
	logic        res_v_q;

	logic        out_free;
	logic        emit_go;
	logic [7:0]  pair;

	assign out_free  = !res_v_q || out_ready;
	assign emit_go   = out_free && (state_q == ST_EMITW || state_q == ST_EMITR);
	assign out_valid = res_v_q;
	assign out_res   = res_q;
	assign q_ready   = (state_q == ST_IDLE);
	assign pair      = {cmd_q.source_node, node_q};

	// Window slot index helper
	function automatic logic [2:0] mod5(input logic [3:0] v);
		logic [3:0] r;
		r = (v >= 4'd5) ? v - 4'd5 : v;
		return r[2:0];
	endfunction

	// Memory writes and registered reads
	always_ff @(posedge clk) begin
		if (state_q == ST_CLR) begin
			occ_mem[clr_q[6:0]]  <= '0;
			fill_mem[clr_q[6:0]] <= '0;
			head_mem[clr_q[6:0]] <= '0;
			tot_mem[clr_q[6:0]]  <= '0;
			len_mem[clr_q]       <= '0;
		end
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					cmd_q <= q_cmd;
					port_q <= {q_cmd.switch_id, q_cmd.port_id};
					fill_q <= fill_mem[{q_cmd.switch_id, q_cmd.port_id}];
					head_q <= head_mem[{q_cmd.switch_id, q_cmd.port_id}];
					tot_q  <= tot_mem[{q_cmd.switch_id, q_cmd.port_id}];
					if (q_cmd.opcode == tpcr_pkg::OP_LOAD) begin
						if ({1'b0, q_cmd.hop_index} < 4'(tpcr_pkg::MAX_HOPS)) begin
							hop_mem[{q_cmd.source_node, q_cmd.dest_node,
								q_cmd.hop_index}] <= {q_cmd.switch_id, q_cmd.port_id};
						end
						len_mem[{q_cmd.source_node, q_cmd.dest_node}] <=
							(q_cmd.hop_count > 4'd8) ? 4'd8 : q_cmd.hop_count;
					end
				end
			end
			ST_PRB1: begin
				widx_q <= 10'(port_q) * 10'd5 + 10'(mod5(
					{1'b0, head_q} + (fill_q >= 3'd5 ? 4'd0 : {1'b0, fill_q})));
			end
			ST_PRB2: begin
				old_q <= win_mem[widx_q];
			end
			ST_HOP: begin
				hop_rd_q <= hop_mem[{pair, hop_q}];
			end
			ST_HOPRD: begin
				occ_rd_q <= occ_mem[hop_rd_q];
			end
			default: ;
		endcase
		if (state_q == ST_WAIT && cmd_q.opcode == tpcr_pkg::OP_PROBE) begin
			win_mem[widx_q] <= cmd_q.queue_depth;
			occ_mem[port_q] <= cmd_q.queue_depth;
			fill_mem[port_q] <= (fill_q >= 3'd5) ? 3'd5 : fill_q + 3'd1;
			head_mem[port_q] <= (fill_q >= 3'd5) ? mod5({1'b0, head_q} + 4'd1) : head_q;
			tot_mem[port_q] <= res_q.window_sum;
		end
		if (state_q == ST_NODE) begin
			len_q <= len_mem[pair];
		end
	end

	logic [18:0] newtot;
	logic [19:0] csum;
	logic [18:0] hcost;
	logic        gt;
	logic [22:0] key;

	// New window total: drop the evicted sample when the window is full
	always_comb begin
		if (fill_q >= 3'd5) begin
			newtot = tot_q - 19'(old_q) + 19'(cmd_q.queue_depth);
		end else begin
			newtot = tot_q + 19'(cmd_q.queue_depth);
		end
		csum  = {1'b0, cost_q} + 20'(occ_rd_q);
		hcost = csum[19] ? tpcr_pkg::SAT19 : csum[18:0];
		key   = {cost_q, node_q};
		gt    = (ins_q != 5'd0) && (rb_q[ins_q[3:0] - 4'd1] > key);
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q   <= '0;
			res_v_q <= 1'b0;
			node_q  <= 4'd0;
			hop_q   <= 3'd0;
			cost_q  <= '0;
			n_q     <= '0;
			ins_q   <= '0;
			emit_q  <= '0;
			res_q   <= '0;
		end else begin
			if (emit_go) begin
				res_v_q <= 1'b1;
			end else if (out_valid && out_ready) begin
				res_v_q <= 1'b0;
			end
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 8'd1;
					if (clr_q == 8'd255) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (q_valid) begin
						case (q_cmd.opcode)
							tpcr_pkg::OP_PROBE: state_q <= ST_PRB1;
							tpcr_pkg::OP_RANK: begin
								node_q <= min_node;
								n_q <= '0;
								state_q <= (min_node > max_node) ? ST_IDLE : ST_NODE;
							end
							default: ;
						endcase
					end
				end
				ST_PRB1: state_q <= ST_PRB2;
				ST_PRB2: state_q <= ST_EMITW;
				ST_EMITW: begin
					if (out_free) begin
						res_q <= '{result_kind: 1'b0, ranked_node: 4'd0, path_cost: '0,
							window_sum: newtot, last: 1'b1};
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					state_q <= ST_IDLE;
				end
				ST_NODE: begin
					hop_q <= 3'd0;
					cost_q <= '0;
					if (node_q == cmd_q.source_node) begin
						if (node_q == max_node) begin
							state_q <= (n_q == 5'd0) ? ST_IDLE : ST_EMITR;
							emit_q <= '0;
						end else begin
							node_q <= node_q + 4'd1;
						end
					end else if (cmd_q.strategy == tpcr_pkg::STRAT_QSUM ||
						cmd_q.strategy == tpcr_pkg::STRAT_HOPS) begin
						state_q <= ST_HOP;
					end else begin
						state_q <= ST_INS;
						ins_q <= n_q;
					end
				end
				ST_HOP: begin
					if (cmd_q.strategy == tpcr_pkg::STRAT_HOPS) begin
						cost_q <= 19'(len_q);
						ins_q <= n_q;
						state_q <= ST_INS;
					end else if ({1'b0, hop_q} >= len_q) begin
						ins_q <= n_q;
						state_q <= ST_INS;
					end else begin
						state_q <= ST_HOPRD;
					end
				end
				ST_HOPRD: begin
					state_q <= ST_INS;
					ins_q <= tpcr_pkg::INS_ACC;
				end
				ST_INS: begin
					if (ins_q == tpcr_pkg::INS_ACC) begin
						// accumulate one hop, then go back for the next or, after the last hop slot, insert
						cost_q <= hcost;
						hop_q <= hop_q + 3'd1;
						state_q <= (hop_q == 3'd7) ? ST_INS : ST_HOP;
						ins_q <= (hop_q == 3'd7) ? n_q : tpcr_pkg::INS_ACC;
					end else if (gt) begin
						rb_q[ins_q[3:0]] <= rb_q[ins_q[3:0] - 4'd1];
						ins_q <= ins_q - 5'd1;
					end else begin
						rb_q[ins_q[3:0]] <= key;
						n_q <= n_q + 5'd1;
						if (node_q == max_node) begin
							state_q <= ST_EMITR;
							emit_q <= '0;
						end else begin
							node_q <= node_q + 4'd1;
							state_q <= ST_NODE;
						end
					end
				end
				ST_EMITR: begin
					if (out_free) begin
						res_q <= '{result_kind: 1'b1,
							ranked_node: rb_q[emit_q[3:0]][3:0],
							path_cost: rb_q[emit_q[3:0]][22:4], window_sum: '0,
							last: (emit_q + 5'd1 == n_q)};
						emit_q <= emit_q + 5'd1;
						if (emit_q + 5'd1 == n_q) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[hw/rtl/telemetry_path_cost_ranker.sv]
// ----------------------------------------------------------------------------
// telemetry_path_cost_ranker
// Probe occupancy tables, path table and cost ranking.
// ----------------------------------------------------------------------------
// A two-entry queue parts the input from the executing back end. After reset
// the back end clears its tables before it takes the first queued item. A
// probe update reads the tables, the window slot and evicted sample, emits
// the result, then updates the window. A hop load is written while idle. A
// rank query visits each other node in range: strategy 0 sums the hops, then
// inserts in order, one shift per cycle; results drain one per cycle if ready.
`include "telemetry_path_cost_ranker_defines.svh"
module telemetry_path_cost_ranker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  opcode,
	input  logic [3:0]  switch_id,
	input  logic [2:0]  port_id,
	input  logic [15:0] queue_depth,
	input  logic [3:0]  source_node,
	input  logic [3:0]  dest_node,
	input  logic [2:0]  hop_index,
	input  logic [3:0]  hop_count,
	input  logic [1:0]  strategy,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        result_kind,
	output logic [3:0]  ranked_node,
	output logic [18:0] path_cost,
	output logic [18:0] window_sum,
	output logic        last
);

	logic [3:0] min_q, max_q;
	tpcr_pkg::cmd_t in_cmd, q_cmd;
	tpcr_pkg::res_t res;
	logic q_valid, q_ready;

	// Configuration registers
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= 4'd0;
			max_q <= 4'd15;
		end else if (psel && penable && pwrite) begin
			if (paddr == tpcr_pkg::REG_MIN_NODE) min_q <= pwdata[3:0];
			if (paddr == tpcr_pkg::REG_MAX_NODE) max_q <= pwdata[3:0];
		end
	end
	always_comb begin
		prdata = 32'd0;
		if (paddr == tpcr_pkg::REG_MIN_NODE) prdata = {28'd0, min_q};
		if (paddr == tpcr_pkg::REG_MAX_NODE) prdata = {28'd0, max_q};
	end

	assign in_cmd = '{opcode: opcode, switch_id: switch_id, port_id: port_id,
		queue_depth: queue_depth, source_node: source_node, dest_node: dest_node,
		hop_index: hop_index, hop_count: hop_count, strategy: strategy};

	tpcr_front u_front (.clk, .arst_n, .in_valid, .in_ready, .in_cmd,
		.q_valid, .q_ready, .q_cmd);

	tpcr_back u_back (.clk, .arst_n, .min_node(min_q), .max_node(max_q),
		.q_valid, .q_ready, .q_cmd, .out_valid, .out_ready, .out_res(res));

	assign result_kind = res.result_kind;
	assign ranked_node = res.ranked_node;
	assign path_cost   = res.path_cost;
	assign window_sum  = res.window_sum;
	assign last        = res.last;

	`TPCR_ASSERT_IMP(a_kind0_last, clk, arst_n, out_valid && !result_kind, last)
	`TPCR_ASSERT_IMP(a_kind0_zero, clk, arst_n, out_valid && !result_kind,
		path_cost == 19'd0 && ranked_node == 4'd0)
	`TPCR_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid)

endmodule
